/* rtl/dtah_pkg.sv */
// Package for the dual-channel averaging thermostat.
// Holds widths, the averaging window, the Q0.24 reciprocal, register codes and shared types.
// No dependencies.
package dtah_pkg;

	localparam int SAMPLES  = 100;
	localparam int SAMPLE_W = 10;
	localparam int TEMP_W   = 8;
	localparam int SUM_W    = 17;
	localparam int CNT_W    = 7;
	localparam int CFG_W    = 8;
	localparam int IDX_W    = 2;
	localparam int FRAC_W   = 24;
	localparam int RECIP_W  = 24;
	localparam int PROD_W   = SUM_W + RECIP_W;

	// ceil(2^24 * 1000 / (2046 * SAMPLES))
	localparam longint unsigned RECIP_NUM = 64'd16777216000;
	localparam longint unsigned RECIP_DEN = 64'd2046 * SAMPLES;
	localparam longint unsigned RECIP_VAL = (RECIP_NUM + RECIP_DEN - 64'd1) / RECIP_DEN;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

	localparam logic [CNT_W:0]  WINDOW_LEN = SAMPLES[CNT_W:0];
	localparam logic [CFG_W-1:0] HIGH_LIMIT_RST = 8'd40;
	localparam logic [CFG_W-1:0] LOW_LIMIT_RST  = 8'd35;
	localparam logic [TEMP_W-1:0] TEMP_MAX      = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_HIGH_LIMIT = 2'd0,
		REG_LOW_LIMIT  = 2'd1
	} cfg_idx_t;

	// Held temperatures after the window update of one request.
	typedef struct packed {
		logic [TEMP_W-1:0] temp_a;
		logic [TEMP_W-1:0] temp_b;
		logic              changed;
	} temps_t;

	// Heater and alarm drive after the hysteresis update.
	typedef struct packed {
		logic heater_on;
		logic alarm_on;
	} drive_t;

endpackage

/* rtl/dtah_ifs.sv */
// Valid/ready channel interfaces for the thermostat: sample pairs in, results out.
// Depends on dtah_pkg for field widths.
interface dtah_sample_if;
	logic                          valid;
	logic                          ready;
	logic [dtah_pkg::SAMPLE_W-1:0] sample_a;
	logic [dtah_pkg::SAMPLE_W-1:0] sample_b;

	modport source (output valid, sample_a, sample_b, input ready);
	modport sink   (input valid, sample_a, sample_b, output ready);
endinterface

interface dtah_result_if;
	logic                        valid;
	logic                        ready;
	logic [dtah_pkg::TEMP_W-1:0] temp_a;
	logic [dtah_pkg::TEMP_W-1:0] temp_b;
	logic                        heater_on;
	logic                        alarm_on;
	logic                        changed;

	modport source (output valid, temp_a, temp_b, heater_on, alarm_on, changed, input ready);
	modport sink   (input valid, temp_a, temp_b, heater_on, alarm_on, changed, output ready);
endinterface

/* rtl/dtah_avg.sv */
// Window accumulators and degree conversion for both channels.
// Depends on dtah_pkg (widths, window length, reciprocal, temps_t).
module dtah_avg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [dtah_pkg::SAMPLE_W-1:0] sample_a,
	input  logic [dtah_pkg::SAMPLE_W-1:0] sample_b,
	output dtah_pkg::temps_t              temps
);

	logic [dtah_pkg::SUM_W-1:0]  sum_a_q, sum_b_q;
	logic [dtah_pkg::CNT_W-1:0]  cnt_q;
	logic [dtah_pkg::TEMP_W-1:0] held_a_q, held_b_q;

	logic [dtah_pkg::SUM_W-1:0]  sum_a_nx, sum_b_nx;
	logic [dtah_pkg::CNT_W:0]    cnt_inc;
	logic                        last;
	logic [dtah_pkg::PROD_W-1:0] prod_a, prod_b;
	logic [dtah_pkg::PROD_W-dtah_pkg::FRAC_W-1:0] deg_a, deg_b;
	logic [dtah_pkg::TEMP_W-1:0] sat_a, sat_b;

	always_comb begin
		sum_a_nx = sum_a_q + {{(dtah_pkg::SUM_W-dtah_pkg::SAMPLE_W){1'b0}}, sample_a};
		sum_b_nx = sum_b_q + {{(dtah_pkg::SUM_W-dtah_pkg::SAMPLE_W){1'b0}}, sample_b};
		cnt_inc  = {1'b0, cnt_q} + {{dtah_pkg::CNT_W{1'b0}}, 1'b1};
		last     = (cnt_inc >= dtah_pkg::WINDOW_LEN);

		prod_a = {{dtah_pkg::RECIP_W{1'b0}}, sum_a_nx} *
			{{dtah_pkg::SUM_W{1'b0}}, dtah_pkg::RECIP};
		prod_b = {{dtah_pkg::RECIP_W{1'b0}}, sum_b_nx} *
			{{dtah_pkg::SUM_W{1'b0}}, dtah_pkg::RECIP};
		deg_a  = prod_a[dtah_pkg::PROD_W-1:dtah_pkg::FRAC_W];
		deg_b  = prod_b[dtah_pkg::PROD_W-1:dtah_pkg::FRAC_W];
		// clamp to the 8-bit degree range
		sat_a  = (deg_a > {{(dtah_pkg::PROD_W-dtah_pkg::FRAC_W-dtah_pkg::TEMP_W){1'b0}},
			dtah_pkg::TEMP_MAX}) ? dtah_pkg::TEMP_MAX : deg_a[dtah_pkg::TEMP_W-1:0];
		sat_b  = (deg_b > {{(dtah_pkg::PROD_W-dtah_pkg::FRAC_W-dtah_pkg::TEMP_W){1'b0}},
			dtah_pkg::TEMP_MAX}) ? dtah_pkg::TEMP_MAX : deg_b[dtah_pkg::TEMP_W-1:0];

		temps.temp_a  = last ? sat_a : held_a_q;
		temps.temp_b  = last ? sat_b : held_b_q;
		temps.changed = last && ((sat_a != held_a_q) || (sat_b != held_b_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			cnt_q    <= '0;
			held_a_q <= '0;
			held_b_q <= '0;
		end else if (step) begin
			if (last) begin
				sum_a_q  <= '0;
				sum_b_q  <= '0;
				cnt_q    <= '0;
				held_a_q <= sat_a;
				held_b_q <= sat_b;
			end else begin
				sum_a_q <= sum_a_nx;
				sum_b_q <= sum_b_nx;
				cnt_q   <= cnt_inc[dtah_pkg::CNT_W-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} < dtah_pkg::WINDOW_LEN))
		else $error("window count left the window");
	a_changed_moves_held: assert property (@(posedge clk) disable iff (!arst_n)
		(step && temps.changed) |=>
		((held_a_q != $past(held_a_q)) || (held_b_q != $past(held_b_q))))
		else $error("changed flagged but held temperatures did not move");
	a_idle_holds_sums: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(sum_a_q) && $stable(sum_b_q) && $stable(cnt_q)))
		else $error("accumulators moved without a request");
`endif

endmodule

/* rtl/dtah_hyst.sv */
// Hysteresis heater control and over-temperature alarm.
// Depends on dtah_pkg (temps_t, drive_t, widths).
module dtah_hyst (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  dtah_pkg::temps_t           temps,
	input  logic [dtah_pkg::CFG_W-1:0] high_limit,
	input  logic [dtah_pkg::CFG_W-1:0] low_limit,
	output dtah_pkg::drive_t           drive
);

	logic heater_q, alarm_q;
	logic over, under, below;

	always_comb begin
		over  = (temps.temp_a > high_limit) || (temps.temp_b > high_limit);
		under = (temps.temp_a < low_limit) && (temps.temp_b < low_limit);
		below = (temps.temp_a < high_limit) && (temps.temp_b < high_limit);
		drive.heater_on = heater_q;
		drive.alarm_on  = alarm_q;
		if (over) begin
			drive.heater_on = 1'b0;
			drive.alarm_on  = 1'b1;
		end else if (under) begin
			drive.heater_on = 1'b1;
		end else if (below) begin
			drive.alarm_on = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= 1'b0;
			alarm_q  <= 1'b0;
		end else if (step) begin
			heater_q <= drive.heater_on;
			alarm_q  <= drive.alarm_on;
		end
	end

`ifndef SYNTHESIS
	a_alarm_needs_over: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(alarm_q) |-> $past(step && over))
		else $error("alarm raised without an over-limit temperature");
	a_heater_needs_under: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(heater_q) |-> $past(step && under && !over))
		else $error("heater switched on outside the low band");
`endif

endmodule

/* rtl/dual_temp_average_hysteresis_ctrl.sv */
// Top level of the dual-channel averaging thermostat with alarm.
// Depends on dtah_pkg, dtah_ifs (channel interfaces), dtah_avg and dtah_hyst.
//
// Usage:
//   samples : valid/ready channel, one request = one pair of 10-bit ADC readings.
//   results : valid/ready channel, one result per request: held temperatures a/b,
//             heater and alarm drive, and a changed flag on window ends.
//   cfg_*   : write-only register port, index 0 = high limit, index 1 = low limit;
//             other indexes are dropped. Write only while no request is in flight.
// Every SAMPLES requests close a window: the sums go through the Q0.24 reciprocal,
// clamp at 255 and become the new held temperatures; hysteresis runs on every request.
// Timing: an input register then one compute pass into the result register. A request
// accepted into the input register is loaded into the result register when the pipe next
// advances, and results.valid rises then. One request per cycle is sustained while
// results.ready stays high; the limit is the accumulate/multiply/compare loop on the
// window state, which is combinational between its registers.
// Stall: while a result is pending, samples.ready follows results.ready; when the
// receiver holds ready low, the result register holds and the whole pipe freezes.
// Reset: arst_n clears sums, window count, held temperatures, heater and alarm, and
// loads the limits with 40 and 35 degrees.
module dual_temp_average_hysteresis_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	dtah_sample_if.sink                    samples,
	dtah_result_if.source                  results,
	input  logic                           cfg_we,
	input  logic [dtah_pkg::IDX_W-1:0]     cfg_index,
	input  logic [dtah_pkg::CFG_W-1:0]     cfg_data
);

	logic [dtah_pkg::CFG_W-1:0] high_limit_q, low_limit_q;

	// input register stage
	logic                          valid_s1;
	logic [dtah_pkg::SAMPLE_W-1:0] sample_a_s1, sample_b_s1;

	// result register stage
	logic                        valid_s2;
	logic [dtah_pkg::TEMP_W-1:0] temp_a_s2, temp_b_s2;
	logic                        heater_s2, alarm_s2, changed_s2;

	logic             advance;
	logic             step;
	dtah_pkg::temps_t temps;
	dtah_pkg::drive_t drive;

	// Advance whenever the result slot is empty or being drained this cycle.
	assign advance       = !valid_s2 || results.ready;
	assign step          = advance && valid_s1;
	assign samples.ready = advance;

	// Limit registers: decode the index, drop unknown codes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_limit_q <= dtah_pkg::HIGH_LIMIT_RST;
			low_limit_q  <= dtah_pkg::LOW_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dtah_pkg::REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				dtah_pkg::REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the incoming request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && samples.valid) begin
			sample_a_s1 <= samples.sample_a;
			sample_b_s1 <= samples.sample_b;
		end
	end

	// Window accumulation and conversion; window state advances on step.
	dtah_avg u_avg (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.sample_a (sample_a_s1),
		.sample_b (sample_b_s1),
		.temps    (temps)
	);

	// Heater/alarm decision on the freshly updated held temperatures.
	dtah_hyst u_hyst (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.temps      (temps),
		.high_limit (high_limit_q),
		.low_limit  (low_limit_q),
		.drive      (drive)
	);

	// Result register: load on step, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			temp_a_s2  <= temps.temp_a;
			temp_b_s2  <= temps.temp_b;
			heater_s2  <= drive.heater_on;
			alarm_s2   <= drive.alarm_on;
			changed_s2 <= temps.changed;
		end
	end

	assign results.valid     = valid_s2;
	assign results.temp_a    = temp_a_s2;
	assign results.temp_b    = temp_b_s2;
	assign results.heater_on = heater_s2;
	assign results.alarm_on  = alarm_s2;
	assign results.changed   = changed_s2;

`ifndef SYNTHESIS
	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_a_s1) && $stable(sample_b_s1)))
		else $error("pending request dropped while stalled");
	a_step_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed request produced no result");
	a_no_step_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !results.ready) |-> !step)
		else $error("window state advanced while result slot blocked");
`endif

endmodule

/* verif/thermo_check_pkg.sv */
// Scoreboard for the dual-channel averaging thermostat: predicts each result from the
// accepted sample pairs and register writes, then checks the results in order.
// Depends on dtah_pkg for widths, the window length, reset limits and register codes.
package thermo_check_pkg;
	import dtah_pkg::*;

	// Q0.24 reciprocal of 2.046 * SAMPLES, rounded up
	localparam longint unsigned DEG_DIV   = 64'd2046 * SAMPLES;
	localparam longint unsigned DEG_RECIP = (64'd16777216000 + DEG_DIV - 64'd1) / DEG_DIV;

	// indexes that decode to no register
	localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [TEMP_W-1:0] temp_a;
		logic [TEMP_W-1:0] temp_b;
		logic              heater_on;
		logic              alarm_on;
		logic              changed;
	} reading_t;

	class thermo_scoreboard;
		logic [CFG_W-1:0]  hi_lim = HIGH_LIMIT_RST;
		logic [CFG_W-1:0]  lo_lim = LOW_LIMIT_RST;
		logic [SUM_W-1:0]  acc_a = '0;
		logic [SUM_W-1:0]  acc_b = '0;
		logic [CNT_W-1:0]  win_cnt = '0;
		logic [TEMP_W-1:0] avg_a = '0;
		logic [TEMP_W-1:0] avg_b = '0;
		logic              heater = 1'b0;
		logic              alarm = 1'b0;
		reading_t          due_readings[$];
		int                mismatches = 0;
		int                seen = 0;

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_HIGH_LIMIT)
				hi_lim = val;
			else if (idx == REG_LOW_LIMIT)
				lo_lim = val;
		endfunction

		function logic [TEMP_W-1:0] to_degrees(logic [SUM_W-1:0] s);
			longint unsigned q;
			q = 64'(s);
			q = (q * DEG_RECIP) >> FRAC_W;
			return (q > 64'd255) ? 8'd255 : q[TEMP_W-1:0];
		endfunction

		// Advance the window with one accepted pair and queue the reading it causes.
		function void note_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
			reading_t          r;
			logic [TEMP_W-1:0] na;
			logic [TEMP_W-1:0] nb;
			acc_a = acc_a + SUM_W'(a);
			acc_b = acc_b + SUM_W'(b);
			r.changed = 1'b0;
			if (int'(win_cnt) + 1 >= SAMPLES) begin
				na = to_degrees(acc_a);
				nb = to_degrees(acc_b);
				r.changed = (na != avg_a) || (nb != avg_b);
				avg_a = na;
				avg_b = nb;
				acc_a = '0;
				acc_b = '0;
				win_cnt = '0;
			end else begin
				win_cnt = win_cnt + CNT_W'(1);
			end
			if (avg_a > hi_lim || avg_b > hi_lim) begin
				heater = 1'b0;
				alarm = 1'b1;
			end else if (avg_a < lo_lim && avg_b < lo_lim) begin
				heater = 1'b1;
			end else if (avg_a < hi_lim && avg_b < hi_lim) begin
				alarm = 1'b0;
			end
			r.temp_a = avg_a;
			r.temp_b = avg_b;
			r.heater_on = heater;
			r.alarm_on = alarm;
			due_readings.push_back(r);
		endfunction

		function void flag(string fld, int want, int got);
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch on reading %0d: %s expected %0d got %0d",
					seen, fld, want, got);
		endfunction

		function void check_reading(logic [TEMP_W-1:0] ta, logic [TEMP_W-1:0] tb,
				logic h, logic al, logic ch);
			reading_t want;
			seen++;
			if (due_readings.size() == 0) begin
				flag("unexpected reading, temp_a", -1, int'(ta));
				return;
			end
			want = due_readings.pop_front();
			if (want.temp_a !== ta)
				flag("temp_a", int'(want.temp_a), int'(ta));
			if (want.temp_b !== tb)
				flag("temp_b", int'(want.temp_b), int'(tb));
			if (want.heater_on !== h)
				flag("heater_on", int'(want.heater_on), int'(h));
			if (want.alarm_on !== al)
				flag("alarm_on", int'(want.alarm_on), int'(al));
			if (want.changed !== ch)
				flag("changed", int'(want.changed), int'(ch));
		endfunction

		function int pending();
			return due_readings.size();
		endfunction
	endclass

endpackage

/* verif/tb_dual_temp_average_hysteresis_ctrl.sv */
// Testbench for dual_temp_average_hysteresis_ctrl: drives sample pairs and limit writes,
// checks every result against the scoreboard in thermo_check_pkg.
// Depends on dtah_pkg, the channel interfaces and thermo_check_pkg.
module tb_dual_temp_average_hysteresis_ctrl;
	timeunit 1ns;
	timeprecision 1ps;

	import dtah_pkg::*;
	import thermo_check_pkg::*;

	localparam int ITEM_TARGET = 1300;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
	localparam int IDLE_PCT    = 33;
	// stretch of requests and results with no idling on either side
	localparam int CALM_FIRST  = 600;
	localparam int CALM_LAST   = 800;
	localparam int HOLD_CYCLES = 80;

	typedef enum logic [1:0] {
		WIN_NEAR_LIMITS,
		WIN_SATURATE,
		WIN_COLD,
		WIN_NOISE
	} win_kind_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dtah_sample_if sample_ch ();
	dtah_result_if result_ch ();

	dual_temp_average_hysteresis_ctrl uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	thermo_scoreboard sb = new();

	// stimulus state
	win_kind_t win_kind = WIN_NOISE;
	int lvl_a = 0;
	int lvl_b = 0;
	int items_sent = 0;
	logic [CFG_W-1:0] cur_hi = HIGH_LIMIT_RST;
	logic [CFG_W-1:0] cur_lo = LOW_LIMIT_RST;
	bit stall_burst_req = 1'b0;

	// corner pairs for the directed opening: all-zero, full scale, one-sided,
	// alternating bit patterns, and values next to the extremes
	int corner_a [12] = '{0, 1023, 0, 1023, 682, 341, 1, 1022, 512, 511, 1023, 0};
	int corner_b [12] = '{0, 1023, 1023, 0, 341, 682, 1, 1022, 511, 512, 1023, 0};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous bound on the whole run; a hang in the handshakes lands here.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Watch every rising edge in one process so that register writes, results and
	// requests reach the scoreboard in a fixed order: a result accepted at this edge
	// always belongs to a request noted at an earlier edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_index, cfg_data);
			if (result_ch.valid && result_ch.ready)
				sb.check_reading(result_ch.temp_a, result_ch.temp_b,
					result_ch.heater_on, result_ch.alarm_on, result_ch.changed);
			if (sample_ch.valid && sample_ch.ready)
				sb.note_pair(sample_ch.sample_a, sample_ch.sample_b);
		end
	end

	// Result side: random back-pressure, one calm stretch, and one long hold-off
	// that the sender asks for while it keeps offering requests, so the pipe fills
	// and the block drops samples.ready.
	initial begin : result_drain
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				result_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_burst_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else if (sb.seen >= CALM_FIRST && sb.seen < CALM_LAST) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Level that should average to a few degrees around one of the current limits.
	function automatic int near_level();
		int deg;
		deg = int'($urandom_range(1) ? cur_hi : cur_lo) + int'($urandom_range(6)) - 3;
		if (deg < 0)
			deg = 0;
		if (deg > 255)
			deg = 255;
		return deg * 2046 / 1000 + 1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] jitter(int lvl);
		int v;
		v = lvl + int'($urandom_range(4)) - 2;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[SAMPLE_W-1:0];
	endfunction

	// Choose the character of the next window. Most windows sit near the limits so
	// the hysteresis sees both sides of each threshold; the second window is forced
	// to full scale so the conversion saturates.
	task automatic plan_window();
		int roll;
		roll = $urandom_range(99);
		if (items_sent == SAMPLES)
			win_kind = WIN_SATURATE;
		else if (roll < 60)
			win_kind = WIN_NEAR_LIMITS;
		else if (roll < 75)
			win_kind = WIN_SATURATE;
		else if (roll < 85)
			win_kind = WIN_COLD;
		else
			win_kind = WIN_NOISE;
		case (win_kind)
			WIN_NEAR_LIMITS: begin
				lvl_a = near_level();
				lvl_b = near_level();
			end
			WIN_SATURATE: begin
				lvl_a = (items_sent == SAMPLES) ? SAMPLE_MAX : int'($urandom_range(SAMPLE_MAX, 530));
				lvl_b = (items_sent == SAMPLES) ? SAMPLE_MAX : int'($urandom_range(SAMPLE_MAX, 530));
			end
			WIN_COLD: begin
				lvl_a = int'($urandom_range(20));
				lvl_b = int'($urandom_range(20));
			end
			default: ;
		endcase
	endtask

	task automatic next_pair(output logic [SAMPLE_W-1:0] a, output logic [SAMPLE_W-1:0] b);
		if (items_sent % SAMPLES == 0)
			plan_window();
		if (win_kind == WIN_NOISE) begin
			a = SAMPLE_W'($urandom_range(SAMPLE_MAX));
			b = SAMPLE_W'($urandom_range(SAMPLE_MAX));
		end else begin
			a = jitter(lvl_a);
			b = jitter(lvl_b);
		end
	endtask

	// Offer one request and hold it until accepted. Entered and left just after a
	// falling edge; valid stays high into the next request unless an idle gap falls.
	task automatic push_pair(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
		bit calm;
		calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				sample_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_a <= a;
		sample_ch.sample_b <= b;
		do @(posedge clk); while (!sample_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every queued reading has come back, then let the
	// pipe settle.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (4) @(negedge clk);
	endtask

	// One register write; the enable drops in the following cycle.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_limits(logic [CFG_W-1:0] hi, logic [CFG_W-1:0] lo);
		cur_hi = hi;
		cur_lo = lo;
		if ($urandom_range(1)) begin
			write_reg(REG_HIGH_LIMIT, hi);
			write_reg(REG_LOW_LIMIT, lo);
		end else begin
			write_reg(REG_LOW_LIMIT, lo);
			write_reg(REG_HIGH_LIMIT, hi);
		end
	endtask

	initial begin : stimulus
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [CFG_W-1:0] hi;
		logic [CFG_W-1:0] lo;
		int phase;
		int n;
		int span;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HIGH_LIMIT;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_a = '0;
		sample_ch.sample_b = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening under the reset limits: corner samples.
		foreach (corner_a[i])
			push_pair(corner_a[i][SAMPLE_W-1:0], corner_b[i][SAMPLE_W-1:0]);
		drain();

		// Writes to unused indexes must leave both limits alone.
		write_reg(REG_SPARE_2, CFG_W'($urandom_range(255)));
		write_reg(REG_SPARE_3, CFG_W'($urandom_range(255)));

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			// The first phases hit the extremes and crossed limits, then a return
			// to the reset values; later phases are random, now and then crossed.
			case (phase)
				0: begin hi = 8'd255; lo = 8'd0; end
				1: begin hi = 8'd0; lo = 8'd255; end
				2: begin hi = 8'd0; lo = 8'd0; end
				3: begin hi = 8'd255; lo = 8'd255; end
				4: begin hi = HIGH_LIMIT_RST; lo = LOW_LIMIT_RST; end
				default: begin
					if ($urandom_range(3) == 0) begin
						hi = CFG_W'($urandom_range(255));
						lo = CFG_W'($urandom_range(255));
					end else begin
						span = int'($urandom_range(15));
						hi = CFG_W'($urandom_range(240, 20));
						lo = (int'(hi) > span) ? CFG_W'(int'(hi) - span) : 8'd0;
					end
				end
			endcase
			write_limits(hi, lo);
			if ($urandom_range(4) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
					CFG_W'($urandom_range(255)));

			n = int'($urandom_range(220, 80));
			for (int i = 0; i < n; i++) begin
				// ask for the long result hold-off early in a phase so that the
				// sender keeps offering requests all through it
				if (phase == 2 && i == 10)
					stall_burst_req = 1'b1;
				// pause the sender mid-phase until the pipe is empty
				if (i == n / 2 && (phase == 1 || $urandom_range(3) == 0))
					drain();
				next_pair(a, b);
				push_pair(a, b);
			end
			drain();
			phase++;
		end

		repeat (8) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
